/* rtl/core/psw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types and constants of the PSK sample window correlator.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int STORE_DEPTH_DEFAULT = 1024;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int OP_W       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int SHIFT_W    = 16;
    localparam int START_W    = 10;
    localparam int LEN_W      = 8;
    localparam int CORR_W     = 35;
    localparam int COUNT_W    = 11;
    localparam int ADDR_MAX_W = 16;
    localparam int ACC_W      = 26;
    localparam int REF_SHIFT  = 10;

    localparam logic [LEN_W-1:0] LEGACY_LEN_RESET = 8'd32;

    localparam logic [OP_W-1:0] OP_FEED   = 3'd0;
    localparam logic [OP_W-1:0] OP_SHIFT  = 3'd1;
    localparam logic [OP_W-1:0] OP_COS    = 3'd2;
    localparam logic [OP_W-1:0] OP_IQ     = 3'd3;
    localparam logic [OP_W-1:0] OP_LEGACY = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SAMPLE_W-1:0] sample_value;
        logic [SHIFT_W-1:0]  shift_amount;
        logic [START_W-1:0]  window_start;
        logic [LEN_W-1:0]    window_length;
    } t_item;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [COUNT_W-1:0]       stored_count;
        logic                     sample_dropped;
    } t_result;

    typedef enum logic [2:0] {
        CMD_REPORT,
        CMD_FEED,
        CMD_COS,
        CMD_IQ,
        CMD_LEGACY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [ADDR_MAX_W-1:0] addr;
        logic [SAMPLE_W-1:0]   sample;
        logic [LEN_W-1:0]      len;
        logic [1:0]            quad;
        logic [COUNT_W-1:0]    count;
        logic                  dropped;
    } t_cmd;

endpackage

/* rtl/core/psw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_front
// Accepts items, keeps pointer, count and phase, and turns each item into
// a command for the back end.
// ----------------------------------------------------------------------------
module psw_front #(
    parameter int STORE_DEPTH = psw_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  psw_pkg::t_item             i_item,
    input  logic                       i_queue_full,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [psw_pkg::LEN_W-1:0]  i_cfg_data,
    output logic                       o_cmd_push,
    output psw_pkg::t_cmd              o_cmd
);
    import psw_pkg::*;

    localparam int PW   = $clog2(STORE_DEPTH);
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int CMPW = (CW > SHIFT_W) ? CW : SHIFT_W;
    localparam int AW   = (CW > START_W) ? CW : START_W;

    logic [PW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_total, n_total;
    logic [2:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_legacy_len;

    logic             w_accept;
    logic [PW-1:0]    w_addend;
    logic [PW:0]      w_sum;
    logic [PW:0]      w_wrap;
    logic             w_in_range;
    logic [AW-1:0]    w_avail;
    logic [LEN_W-1:0] w_lim;
    logic [LEN_W-1:0] w_n;

    assign w_accept    = i_push && !i_queue_full;
    assign o_cmd_push  = w_accept;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (i_item.operation)
            OP_FEED:  w_addend = PW'(r_total);
            OP_SHIFT: w_addend = PW'(i_item.shift_amount);
            default:  w_addend = PW'(i_item.window_start);
        endcase
    end

    assign w_sum  = {1'b0, r_ptr} + {1'b0, w_addend};
    assign w_wrap = (w_sum >= (PW+1)'(STORE_DEPTH)) ? w_sum - (PW+1)'(STORE_DEPTH) : w_sum;

    assign w_in_range = AW'(i_item.window_start) < AW'(r_total);
    assign w_avail    = AW'(r_total) - AW'(i_item.window_start);
    assign w_lim      = (i_item.operation == OP_LEGACY) ? r_legacy_len : i_item.window_length;
    assign w_n        = !w_in_range ? '0 :
                        (w_avail < AW'(w_lim)) ? w_avail[LEN_W-1:0] : w_lim;

    always_comb begin
        n_ptr   = r_ptr;
        n_total = r_total;
        n_phase = r_phase;
        o_cmd.kind    = CMD_REPORT;
        o_cmd.addr    = ADDR_MAX_W'(w_wrap[PW-1:0]);
        o_cmd.sample  = i_item.sample_value;
        o_cmd.len     = w_n;
        o_cmd.quad    = i_item.window_start[1:0] + r_phase[1:0];
        o_cmd.dropped = 1'b0;
        case (i_item.operation)
            OP_FEED: begin
                if (r_total < CW'(STORE_DEPTH)) begin
                    o_cmd.kind = CMD_FEED;
                    n_total    = r_total + 1'b1;
                end else begin
                    o_cmd.dropped = 1'b1;
                end
            end
            OP_SHIFT: begin
                if (CMPW'(i_item.shift_amount) >= CMPW'(r_total)) begin
                    n_ptr   = '0;
                    n_total = '0;
                end else begin
                    n_ptr   = w_wrap[PW-1:0];
                    n_total = r_total - CW'(i_item.shift_amount);
                end
                n_phase = r_phase + i_item.shift_amount[2:0];
            end
            OP_COS:    o_cmd.kind = CMD_COS;
            OP_IQ:     o_cmd.kind = CMD_IQ;
            OP_LEGACY: o_cmd.kind = CMD_LEGACY;
            default:   o_cmd.kind = CMD_REPORT;
        endcase
        o_cmd.count = COUNT_W'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_total      <= '0;
            r_phase      <= '0;
            r_legacy_len <= LEGACY_LEN_RESET;
        end else begin
            if (w_accept) begin
                r_ptr   <= n_ptr;
                r_total <= n_total;
                r_phase <= n_phase;
            end
            if (i_cfg_valid) begin
                r_legacy_len <= i_cfg_data;
            end
        end
    end

endmodule

/* rtl/core/psw_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module psw_cmd_fifo #(
    parameter int QUEUE_DEPTH = psw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output psw_pkg::t_cmd o_cmd
);
    import psw_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int UW  = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_slot [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [UW-1:0]  r_used;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_used == UW'(QUEUE_DEPTH));
    assign o_valid = (r_used != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_used <= r_used + 1'b1;
            end else if (w_pop && !w_push) begin
                r_used <= r_used - 1'b1;
            end
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(QUEUE_DEPTH))
        else $error("command queue over capacity");

    a_used_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_used == $past(r_used) + 1'b1))
        else $error("command queue count missed a push");

    a_used_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_used == $past(r_used) - 1'b1))
        else $error("command queue count missed a pop");

endmodule

/* rtl/core/psw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_back
// Executes commands: writes fed samples, walks correlation windows through
// the sample memory one sample a cycle, and holds the result register.
// ----------------------------------------------------------------------------
module psw_back #(
    parameter int STORE_DEPTH = psw_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  psw_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output psw_pkg::t_result o_result
);
    import psw_pkg::*;

    localparam int PW = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [PW-1:0]           r_addr;
    logic [LEN_W-1:0]        r_left;
    logic [1:0]              r_quad;
    logic                    r_par;
    logic                    r_rd_valid;
    logic [1:0]              r_rd_quad;
    logic                    r_rd_par;
    logic [SAMPLE_W-1:0]     r_rd_data;
    logic signed [ACC_W-1:0] r_acc_c, n_acc_c;
    logic signed [ACC_W-1:0] r_acc_s, n_acc_s;
    logic                    r_out_valid;
    t_result                 r_out;
    logic [SAMPLE_W-1:0]     r_mem [STORE_DEPTH];

    logic                     w_out_free;
    logic                     w_is_corr;
    logic                     w_acc_clr;
    logic                     w_out_load;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic signed [ACC_W-1:0]  w_samp;
    logic signed [ACC_W-1:0]  w_mag_c;
    logic signed [ACC_W-1:0]  w_mag_s;
    logic signed [CORR_W-1:0] w_cos;
    logic signed [CORR_W-1:0] w_sin;
    logic signed [CORR_W-1:0] w_corr;

    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;
    assign w_out_free = !r_out_valid || i_pop;
    assign w_is_corr  = (i_cmd.kind == CMD_COS) || (i_cmd.kind == CMD_IQ)
                        || (i_cmd.kind == CMD_LEGACY);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid && (w_is_corr || w_out_free);
    assign w_acc_clr  = o_cmd_pop && w_is_corr;
    assign w_out_load = (o_cmd_pop && !w_is_corr) || ((r_state == S_DONE) && w_out_free);
    assign w_mem_we   = o_cmd_pop && (i_cmd.kind == CMD_FEED);
    assign w_mem_re   = (r_state == S_RUN) && (r_left != '0);
    assign w_samp     = ACC_W'(r_rd_data);

    always_comb begin
        n_acc_c = r_acc_c;
        n_acc_s = r_acc_s;
        if (w_acc_clr) begin
            n_acc_c = '0;
            n_acc_s = '0;
        end else if (r_rd_valid) begin
            if (r_cmd.kind == CMD_LEGACY) begin
                n_acc_c = r_rd_par ? r_acc_c - w_samp : r_acc_c + w_samp;
            end else begin
                case (r_rd_quad)
                    2'd0:    n_acc_c = r_acc_c + w_samp;
                    2'd1:    n_acc_s = r_acc_s + w_samp;
                    2'd2:    n_acc_c = r_acc_c - w_samp;
                    default: n_acc_s = r_acc_s - w_samp;
                endcase
            end
        end
    end

    assign w_mag_c = (r_acc_c < 0) ? -r_acc_c : r_acc_c;
    assign w_mag_s = (r_acc_s < 0) ? -r_acc_s : r_acc_s;
    assign w_cos   = CORR_W'({r_acc_c, {REF_SHIFT{1'b0}}});
    assign w_sin   = CORR_W'({r_acc_s, {REF_SHIFT{1'b0}}});

    always_comb begin
        case (r_cmd.kind)
            CMD_COS:    w_corr = w_cos;
            CMD_IQ:     w_corr = (w_mag_c >= w_mag_s) ? w_cos : w_sin;
            CMD_LEGACY: w_corr = CORR_W'(r_acc_c);
            default:    w_corr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_cmd.addr[PW-1:0]] <= i_cmd.sample;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_rd_valid <= w_mem_re;
            if (w_mem_re) begin
                r_rd_quad <= r_quad;
                r_rd_par  <= r_par;
                r_addr    <= (r_addr == PW'(STORE_DEPTH - 1)) ? '0 : r_addr + 1'b1;
                r_quad    <= r_quad + 1'b1;
                r_par     <= !r_par;
                r_left    <= r_left - 1'b1;
            end
            r_acc_c <= n_acc_c;
            r_acc_s <= n_acc_s;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (w_is_corr) begin
                            r_cmd   <= i_cmd;
                            r_addr  <= i_cmd.addr[PW-1:0];
                            r_left  <= i_cmd.len;
                            r_quad  <= i_cmd.quad;
                            r_par   <= 1'b0;
                            r_state <= S_RUN;
                        end else begin
                            r_out.correlation    <= '0;
                            r_out.stored_count   <= i_cmd.count;
                            r_out.sample_dropped <= i_cmd.dropped;
                        end
                    end
                end
                S_RUN: begin
                    if (r_left == '0 && !r_rd_valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.correlation    <= w_corr;
                        r_out.stored_count   <= r_cmd.count;
                        r_out.sample_dropped <= 1'b0;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> i_cmd_valid)
        else $error("command taken from empty queue");

    a_read_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_RUN))
        else $error("sample read outside window walk");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_left == '0) |=> !r_rd_valid)
        else $error("sample read past window end");

endmodule

/* rtl/core/psk_sample_window_correlator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_sample_window_correlator
// Sample window store with feed, shift and carrier correlation operations.
//
// channel   direction  transfer when             payload
// input     in         push && !full            i_item   (t_item)
// result    out        pop && !empty            o_result (t_result)
// config    in         i_cfg_valid&&o_cfg_ready i_cfg_data (legacy window)
//
// Feed, shift and unknown operations finish in the idle state and load the result register directly.
// A correlation reads its window through the single read port of the sample
// memory, which delivers one sample per cycle.
// The front end accepts one item per cycle until the command queue fills.
// Synchronous active-low reset; no memory clearing pass.
// A result waiting in the output register stalls the back end; the input
// stalls once the command queue behind it fills.
// ----------------------------------------------------------------------------
module psk_sample_window_correlator #(
    parameter int STORE_DEPTH = psw_pkg::STORE_DEPTH_DEFAULT,
    parameter int QUEUE_DEPTH = psw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  psw_pkg::t_item            i_item,
    output logic                      empty,
    input  logic                      pop,
    output psw_pkg::t_result          o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [psw_pkg::LEN_W-1:0] i_cfg_data
);
    import psw_pkg::*;

    t_cmd w_front_cmd;
    logic w_front_push;
    t_cmd w_queue_cmd;
    logic w_queue_valid;
    logic w_queue_pop;

    psw_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_item),
        .i_queue_full (full),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_cmd_push   (w_front_push),
        .o_cmd        (w_front_cmd)
    );

    psw_cmd_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_cmd   (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_queue_pop),
        .o_valid (w_queue_valid),
        .o_cmd   (w_queue_cmd)
    );

    psw_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_queue_valid),
        .i_cmd       (w_queue_cmd),
        .o_cmd_pop   (w_queue_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PSK sample window correlator. A scripted
// opening hits the empty store, field extremes, reserved operations, windows
// past the stored data and an IQ magnitude tie. Randomized phases follow, one
// per legacy window setting (0 and 255 among them), one of which fills the
// store until feeds drop. A local model of the store, phase and sums predicts
// every result that the script does not give. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import psw_pkg::*;

    localparam int          DEPTH        = STORE_DEPTH_DEFAULT;
    localparam longint      CARRIER_AMP  = 1024;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          N_PHASES     = 6;
    localparam logic [2:0]  OP_RSVD5     = 3'd5;
    localparam logic [2:0]  OP_RSVD6     = 3'd6;
    localparam logic [2:0]  OP_RSVD7     = 3'd7;

    typedef struct {
        t_item   it;
        bit      known;
        t_result res;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    t_item            i_item = '0;
    logic             empty;
    logic             pop = 1'b0;
    t_result          o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [LEN_W-1:0] i_cfg_data = '0;

    // local copy of the block state
    logic [SAMPLE_W-1:0] sample_mem [DEPTH];
    logic [9:0]          head_ptr = '0;
    int unsigned         held = 0;
    logic [2:0]          carrier_ph = '0;
    logic [LEN_W-1:0]    legacy_len = LEGACY_LEN_RESET;

    t_result     pending_results [$];
    t_row        script [$];
    t_result     want;
    int unsigned pop_wait = 0;
    int unsigned pop_draw;
    bit          idle_in = 1'b1;
    bit          idle_out = 1'b1;
    int          n_err = 0;
    int          n_sent = 0;
    int          n_op [8];
    int          n_drop = 0;
    int          n_flush = 0;
    int          n_cfg = 0;
    int unsigned peak_held = 0;

    psk_sample_window_correlator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result window_result(input t_item it);
        t_result     r;
        longint      re;
        longint      im;
        longint      acc;
        longint      s;
        int unsigned pos;
        logic [2:0]  k;
        r = '0;
        re = 0;
        im = 0;
        acc = 0;
        case (it.operation)
            OP_FEED: begin
                if (held < DEPTH) begin
                    sample_mem[10'(head_ptr + held)] = it.sample_value;
                    held++;
                end else begin
                    r.sample_dropped = 1'b1;
                end
            end
            OP_SHIFT: begin
                if (it.shift_amount >= held) begin
                    held = 0;
                    head_ptr = '0;
                end else begin
                    head_ptr = head_ptr + it.shift_amount[9:0];
                    held -= it.shift_amount;
                end
                carrier_ph = carrier_ph + it.shift_amount[2:0];
            end
            OP_COS, OP_IQ: begin
                for (int j = 0; j < it.window_length && it.window_start + j < held; j++) begin
                    pos = it.window_start + j;
                    k = 3'(pos) + carrier_ph;
                    s = longint'(sample_mem[10'(head_ptr + pos)]) * CARRIER_AMP;
                    case (k[1:0])
                        2'd0: re += s;
                        2'd1: im += s;
                        2'd2: re -= s;
                        default: im -= s;
                    endcase
                end
                if (it.operation == OP_COS || (re < 0 ? -re : re) >= (im < 0 ? -im : im))
                    acc = re;
                else
                    acc = im;
            end
            OP_LEGACY: begin
                for (int j = 0; j < legacy_len && it.window_start + j < held; j++) begin
                    s = longint'(sample_mem[10'(head_ptr + it.window_start + j)]);
                    acc += (j % 2 == 1) ? -s : s;
                end
            end
            default: ;
        endcase
        r.correlation = CORR_W'(acc);
        r.stored_count = COUNT_W'(held);
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] op, input logic [15:0] smp,
                                    input logic [15:0] sh, input logic [9:0] st,
                                    input logic [7:0] len, input bit known = 1'b0,
                                    input longint corr = 0, input int cnt = 0);
        t_row row;
        row.it = '{operation: op, sample_value: smp, shift_amount: sh,
                   window_start: st, window_length: len};
        row.known = known;
        row.res = '{correlation: CORR_W'(corr), stored_count: COUNT_W'(cnt),
                    sample_dropped: 1'b0};
        script.push_back(row);
    endfunction

    function automatic t_item draw_item(input bit feed_only);
        t_item       it;
        int unsigned pick;
        it.sample_value = 16'($urandom);
        it.shift_amount = 16'($urandom);
        it.window_start = 10'($urandom);
        it.window_length = 8'($urandom);
        pick = feed_only ? 0 : $urandom_range(0, 99);
        if (pick < 40) begin
            it.operation = OP_FEED;
        end else if (pick < 52) begin
            it.operation = OP_SHIFT;
            pick = $urandom_range(0, 19);
            if (pick < 12)
                it.shift_amount = 16'($urandom_range(0, 16));
            else if (pick < 17)
                it.shift_amount = 16'($urandom_range(0, held + 4));
            else if (pick < 18)
                it.shift_amount = 16'(held);
        end else if (pick < 95) begin
            it.operation = (pick < 67) ? OP_COS : (pick < 82) ? OP_IQ : OP_LEGACY;
            if ($urandom_range(0, 9) < 7)
                it.window_start = 10'($urandom_range(0, held > 1023 ? 1023 : held));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                it.window_length = 8'($urandom_range(0, 40));
            else if (pick == 9)
                it.window_length = 8'd255;
        end else begin
            it.operation = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end
        return it;
    endfunction

    task automatic issue_item(input t_item it, input bit known, input t_result typed);
        int unsigned gap;
        t_result     r;
        if (n_sent % 64 == 0) begin
            idle_in = $urandom_range(0, 3) != 0;
            idle_out = $urandom_range(0, 3) != 0;
        end
        gap = idle_in ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (it.operation == OP_SHIFT && it.shift_amount >= held)
            n_flush++;
        r = window_result(it);
        if (r.sample_dropped)
            n_drop++;
        if (held > peak_held)
            peak_held = held;
        n_op[it.operation]++;
        n_sent++;
        pending_results.push_back(known ? typed : r);
    endtask

    task automatic write_legacy_len(input logic [LEN_W-1:0] v);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        legacy_len = v;
        n_cfg++;
    endtask

    // result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_wait <= 0;
        end else if (pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: corr %0d count %0d dropped %0b", $time,
                         o_result.correlation, o_result.stored_count,
                         o_result.sample_dropped);
                n_err++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.correlation !== want.correlation) begin
                    $display("%0t: correlation expected %0d got %0d", $time,
                             want.correlation, o_result.correlation);
                    n_err++;
                end
                if (o_result.stored_count !== want.stored_count) begin
                    $display("%0t: stored_count expected %0d got %0d", $time,
                             want.stored_count, o_result.stored_count);
                    n_err++;
                end
                if (o_result.sample_dropped !== want.sample_dropped) begin
                    $display("%0t: sample_dropped expected %0b got %0b", $time,
                             want.sample_dropped, o_result.sample_dropped);
                    n_err++;
                end
            end
            pop_draw = idle_out ? $urandom_range(0, 16) : 0;
            if (pop_draw != 0) begin
                pop <= 1'b0;
                pop_wait <= pop_draw - 1;
            end
        end else if (!pop) begin
            if (pop_wait == 0)
                pop <= 1'b1;
            else
                pop_wait <= pop_wait - 1;
        end
    end

    initial begin
        logic [LEN_W-1:0] len_plan [N_PHASES];
        len_plan[0] = 8'd0;
        len_plan[1] = 8'd255;
        len_plan[2] = 8'd1;
        len_plan[3] = 8'($urandom);
        len_plan[4] = 8'd2;
        len_plan[5] = 8'($urandom_range(3, 254));

        // empty store, reserved op with all ones
        add_row(OP_COS,    16'h0000, 16'h0000, 10'd0,   8'd255, 1'b1, 0, 0);
        add_row(OP_IQ,     16'h0000, 16'h0000, 10'd0,   8'd255, 1'b1, 0, 0);
        add_row(OP_LEGACY, 16'h0000, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 0);
        add_row(OP_RSVD5,  16'hFFFF, 16'hFFFF, 10'h3FF, 8'hFF,  1'b1, 0, 0);
        add_row(OP_SHIFT,  16'h0000, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 0);
        add_row(OP_FEED,   16'hFFFF, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 1);
        add_row(OP_FEED,   16'h0000, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 2);
        add_row(OP_FEED,   16'h8000, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 3);
        add_row(OP_FEED,   16'h7FFF, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 4);
        add_row(OP_COS,    16'h0000, 16'h0000, 10'd0,   8'd255);
        add_row(OP_IQ,     16'h0000, 16'h0000, 10'd1,   8'd255);
        add_row(OP_IQ,     16'h0000, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 4);
        add_row(OP_LEGACY, 16'h0000, 16'h0000, 10'd0,   8'd0);
        add_row(OP_LEGACY, 16'h0000, 16'h0000, 10'h3FF, 8'd0,   1'b1, 0, 4);
        add_row(OP_COS,    16'h0000, 16'h0000, 10'd4,   8'd10,  1'b1, 0, 4);
        add_row(OP_SHIFT,  16'h0000, 16'h0001, 10'd0,   8'd0,   1'b1, 0, 3);
        add_row(OP_IQ,     16'h0000, 16'h0000, 10'd0,   8'd255);
        // flush past the count, phase wraps back to zero
        add_row(OP_SHIFT,  16'h0000, 16'hFFFF, 10'd0,   8'd0,   1'b1, 0, 0);
        add_row(OP_FEED,   16'h0000, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 1);
        add_row(OP_FEED,   16'h0007, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 2);
        add_row(OP_FEED,   16'h0007, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 3);
        // |cos| == |sin| with opposite signs: cosine sum wins
        add_row(OP_IQ,     16'h0000, 16'h0000, 10'd0,   8'd3,   1'b1, -7168, 3);
        add_row(OP_RSVD7,  16'hFFFF, 16'hFFFF, 10'h3FF, 8'hFF,  1'b1, 0, 3);
        add_row(OP_RSVD6,  16'h0000, 16'h0000, 10'd0,   8'd0,   1'b1, 0, 3);
        add_row(OP_COS,    16'h0000, 16'h0000, 10'd0,   8'd1,   1'b1, 0, 3);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            issue_item(script[i].it, script[i].known, script[i].res);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_legacy_len(len_plan[ph]);
            if (ph == 2) begin
                while (held < DEPTH)
                    issue_item(draw_item(1'b1), 1'b0, '0);
                repeat (6) issue_item(draw_item(1'b1), 1'b0, '0);
            end
            repeat (PHASE_ITEMS) issue_item(draw_item(1'b0), 1'b0, '0);
        end
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Ran %0d items: %0d feeds (%0d dropped), %0d shifts (%0d flushes),",
                 n_sent, n_op[OP_FEED], n_drop, n_op[OP_SHIFT], n_flush);
        $display("%0d cos / %0d IQ / %0d legacy, peak count %0d, %0d window settings",
                 n_op[OP_COS], n_op[OP_IQ], n_op[OP_LEGACY], peak_held, n_cfg);
        if (n_err == 0)
            $display("[psk_sample_window_correlator] OK");
        else
            $display("[psk_sample_window_correlator] ERROR");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("[psk_sample_window_correlator] ERROR");
        $finish;
    end

endmodule

/* psk_sample_window_correlator.f */
rtl/core/psw_pkg.sv
rtl/core/psw_front.sv
rtl/core/psw_cmd_fifo.sv
rtl/core/psw_back.sv
rtl/core/psk_sample_window_correlator.sv
tb/testbench.sv
